@@ rtl/core/nrpe_pkg.sv @@
`default_nettype none

package nrpe_pkg;

  // word width of the radicand; magnitudes use one bit less
  localparam int DATA_WIDTH = 32;
  localparam int MAG_WIDTH  = DATA_WIDTH - 1;
  localparam int DCNT_WIDTH = $clog2(MAG_WIDTH + 1);

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NEG_EVEN = 2'd1;
  localparam logic [1:0] STATUS_DEG_ZERO = 2'd2;

  localparam logic [1:0] FORM_ROOT    = 2'd0;
  localparam logic [1:0] FORM_INTEGER = 2'd1;
  localparam logic [1:0] FORM_PRODUCT = 2'd2;

  typedef struct packed {
    logic [5:0]                   root_degree;
    logic signed [DATA_WIDTH-1:0] radicand_in;
  } request_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic [MAG_WIDTH-1:0]         coefficient;
    logic signed [DATA_WIDTH-1:0] radicand_out;
    logic [1:0]                   form_kind;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_POW_MUL,
    S_POW_CHK,
    S_DIV,
    S_DIV_CHK,
    S_COEF,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic pow_init;
    logic pow_mul;
    logic pow_take;
    logic div_init;
    logic div_step;
    logic div_take;
    logic coef_mul;
    logic coef_take;
    logic d_inc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_loop;
    logic pow_over;
    logic pow_last;
    logic div_last;
    logic div_exact;
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/core/nrpe_ctrl.sv @@
`default_nettype none

module nrpe_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire nrpe_pkg::stat_t stat,
  output nrpe_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 done
);

  nrpe_pkg::state_t state;
  nrpe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nrpe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nrpe_pkg::S_IDLE: begin
        if (start) state_next = nrpe_pkg::S_SETUP;
      end
      nrpe_pkg::S_SETUP: begin
        state_next = stat.need_loop ? nrpe_pkg::S_POW_MUL : nrpe_pkg::S_DONE;
      end
      nrpe_pkg::S_POW_MUL: state_next = nrpe_pkg::S_POW_CHK;
      nrpe_pkg::S_POW_CHK: begin
        if (stat.pow_over) state_next = nrpe_pkg::S_DONE;
        else if (stat.pow_last) state_next = nrpe_pkg::S_DIV;
        else state_next = nrpe_pkg::S_POW_MUL;
      end
      nrpe_pkg::S_DIV: begin
        if (stat.div_last) state_next = nrpe_pkg::S_DIV_CHK;
      end
      nrpe_pkg::S_DIV_CHK: begin
        state_next = stat.div_exact ? nrpe_pkg::S_COEF : nrpe_pkg::S_POW_MUL;
      end
      nrpe_pkg::S_COEF: state_next = nrpe_pkg::S_POW_MUL;
      nrpe_pkg::S_DONE: state_next = nrpe_pkg::S_IDLE;
      default: state_next = nrpe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      nrpe_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      nrpe_pkg::S_SETUP: begin
        cmd.pow_init = stat.need_loop;
      end
      nrpe_pkg::S_POW_MUL: begin
        cmd.pow_mul = 1'b1;
      end
      nrpe_pkg::S_POW_CHK: begin
        cmd.pow_take = !stat.pow_over;
        cmd.div_init = !stat.pow_over && stat.pow_last;
      end
      nrpe_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
      end
      nrpe_pkg::S_DIV_CHK: begin
        cmd.div_take = stat.div_exact;
        cmd.coef_mul = stat.div_exact;
        cmd.d_inc    = !stat.div_exact;
        cmd.pow_init = !stat.div_exact;
      end
      nrpe_pkg::S_COEF: begin
        cmd.coef_take = 1'b1;
        cmd.pow_init  = 1'b1;
      end
      nrpe_pkg::S_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/nrpe_datapath.sv @@
`default_nettype none

module nrpe_datapath (
  input  wire logic               clk,
  input  wire nrpe_pkg::request_t request,
  input  wire nrpe_pkg::cmd_t     cmd,
  output nrpe_pkg::stat_t         stat,
  output nrpe_pkg::result_t       result
);

  localparam int DW = nrpe_pkg::DATA_WIDTH;
  localparam int W  = nrpe_pkg::MAG_WIDTH;
  localparam int CW = nrpe_pkg::DCNT_WIDTH;

  logic [5:0]    degree;
  logic [1:0]    status;
  logic          need_loop;
  logic [DW-1:0] rem;
  logic [W-1:0]  coef;
  logic [W-1:0]  d;
  logic [W-1:0]  p;
  logic [5:0]    ecnt;
  logic [2*W-1:0] prod;
  logic [W-1:0]  r;
  logic [W-1:0]  q;
  logic [CW-1:0] dcnt;

  logic          in_neg;
  logic          in_big;
  logic [1:0]    in_status;
  logic [W-1:0]  mul_a;
  logic [W:0]    r_sh;
  logic          r_ge;

  assign in_neg = request.radicand_in[DW-1];
  assign in_big = !in_neg && (request.radicand_in[W-1:0] >= W'(2));

  always_comb begin
    if (request.root_degree == 6'd0) in_status = nrpe_pkg::STATUS_DEG_ZERO;
    else if (!request.root_degree[0] && in_neg) in_status = nrpe_pkg::STATUS_NEG_EVEN;
    else in_status = nrpe_pkg::STATUS_OK;
  end

  // one shared multiplier: power build-up or coefficient update
  assign mul_a = cmd.coef_mul ? coef : p;

  // restoring division, one quotient bit a step
  assign r_sh = {r, q[W-1]};
  assign r_ge = r_sh >= {1'b0, p};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      degree    <= request.root_degree;
      status    <= in_status;
      need_loop <= (in_status == nrpe_pkg::STATUS_OK) && in_big
                   && (request.root_degree >= 6'd2);
      d         <= W'(2);
      if ((in_status == nrpe_pkg::STATUS_OK) && in_big
          && (request.root_degree == 6'd1)) begin
        coef <= request.radicand_in[W-1:0];
        rem  <= DW'(1);
      end else begin
        coef <= W'(1);
        rem  <= request.radicand_in;
      end
    end
    if (cmd.pow_init) begin
      p    <= W'(1);
      ecnt <= 6'd0;
    end
    if (cmd.pow_mul || cmd.coef_mul) begin
      prod <= mul_a * d;
    end
    if (cmd.pow_take) begin
      p    <= prod[W-1:0];
      ecnt <= 6'(ecnt + 6'd1);
    end
    if (cmd.div_init) begin
      r    <= '0;
      q    <= rem[W-1:0];
      dcnt <= '0;
    end
    if (cmd.div_step) begin
      r    <= r_ge ? W'(r_sh - {1'b0, p}) : r_sh[W-1:0];
      q    <= {q[W-2:0], r_ge};
      dcnt <= CW'(dcnt + CW'(1));
    end
    if (cmd.div_take) begin
      rem <= {1'b0, q};
    end
    if (cmd.coef_take) begin
      coef <= prod[W-1:0];
    end
    if (cmd.d_inc) begin
      d <= W'(d + W'(1));
    end
  end

  assign stat.need_loop = need_loop;
  assign stat.pow_over  = prod > {{W{1'b0}}, rem[W-1:0]};
  assign stat.pow_last  = 6'(ecnt + 6'd1) == degree;
  assign stat.div_last  = dcnt == CW'(W - 1);
  assign stat.div_exact = r == '0;

  always_comb begin
    if (status != nrpe_pkg::STATUS_OK) begin
      result.status       = status;
      result.coefficient  = W'(1);
      result.radicand_out = '0;
      result.form_kind    = nrpe_pkg::FORM_ROOT;
    end else begin
      result.status       = nrpe_pkg::STATUS_OK;
      result.coefficient  = coef;
      result.radicand_out = rem;
      if (coef == W'(1)) result.form_kind = nrpe_pkg::FORM_ROOT;
      else if (rem == DW'(1)) result.form_kind = nrpe_pkg::FORM_INTEGER;
      else result.form_kind = nrpe_pkg::FORM_PRODUCT;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nth_root_power_extract_unit.sv @@
// nth root power extraction: n-th root of R rewritten as c times n-th root of r
//
// input channel: request (root_degree, radicand_in) is taken on a rising edge
//   with start high and busy low; busy then stays high until the result is out
// output channel: result (status, coefficient, radicand_out, form_kind) shows
//   for exactly one cycle with done high; the receiver cannot stall, so the
//   beat is consumed at the edge that ends that cycle
// sequence: error cases, n = 1, negative or small radicands go from the
//   setup state straight to the done state;
//   otherwise trial division over d = 2, 3, ...
//   each power attempt runs a mul state then a compare state per multiply, up to
//   n multiplies, and each candidate whose power fits adds a 31-step restoring
//   division plus a check state, and a coefficient state when a factor
//   is taken out; the run time is set by the shared multiplier and the
//   one-bit-a-step divider; the worst case is n = 2 with a large prime,
//   near 46k candidates
// throughput: one item at a time; start is taken again the cycle after done
// reset: rst is synchronous, returns the controller to idle, busy low, no done

`default_nettype none

module nth_root_power_extract_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire nrpe_pkg::request_t request,
  output logic                    busy,
  output logic                    done,
  output nrpe_pkg::result_t       result
);

  // command and status between sequencer and datapath
  nrpe_pkg::cmd_t  cmd;
  nrpe_pkg::stat_t stat;

  // sequencer: power build-up, division, coefficient update
  nrpe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath: shared multiplier, restoring divider, result formatting
  nrpe_datapath u_datapath (
    .clk     (clk),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

endmodule

`default_nettype wire

@@ rtl/core/nrpe_checker.sv @@
`default_nettype none

module nrpe_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire nrpe_pkg::result_t result
);

  // accepted beat keeps the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done longer than one cycle");

  // error results carry the fixed payload
  a_err_payload: assert property (@(posedge clk) disable iff (rst)
    done && (result.status != nrpe_pkg::STATUS_OK) |->
      (result.coefficient == 1) && (result.radicand_out == 0)
      && (result.form_kind == nrpe_pkg::FORM_ROOT))
    else $error("error result payload wrong");

  // plain integer form leaves one under the root
  a_int_form: assert property (@(posedge clk) disable iff (rst)
    done && (result.form_kind == nrpe_pkg::FORM_INTEGER) |->
      (result.radicand_out == 1) && (result.coefficient != 1))
    else $error("integer form inconsistent");

endmodule

bind nth_root_power_extract_unit nrpe_checker u_nrpe_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

@@ tb/nth_root_power_extract_unit_tb.sv @@
`timescale 1ns / 1ps

module nth_root_power_extract_unit_tb;
  import nrpe_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 5;
  localparam int RANDOM_ITEMS = 100;
  // every so many accepted beats the sender holds off until the unit has drained
  localparam int DRAIN_EVERY = 16;
  localparam int TAIL_CYCLES = 16;
  localparam int MAX_REPORTS = 10;
  localparam longint unsigned POS_MAX = 64'h7FFF_FFFF;
  // time limit for the whole run, checked by the watchdog
  localparam longint RUN_LIMIT_NS = 40_000_000;

  typedef struct {
    request_t req;
    result_t  res;
  } root_check_t;

  logic     clk     = 1'b0;
  logic     rst     = 1'b1;
  logic     start   = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  request_t    pending_requests[$];
  root_check_t predicted_roots[$];

  int gap_left       = 0;
  int burst_left     = 0;
  int accepted_count = 0;
  bit drain_wait     = 1'b0;
  int error_count    = 0;

  nth_root_power_extract_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // expected simplification of the n-th root: trial division by d^n for d = 2, 3, ...
  function automatic result_t predict_root(request_t req);
    logic [5:0]        n;
    logic [31:0]       raw;
    longint unsigned   coef;
    longint unsigned   rem;
    longint unsigned   d;
    longint unsigned   p;
    bit                fits;
    int                i;
    result_t           r;
    n   = req.root_degree;
    raw = req.radicand_in;
    r.status       = STATUS_OK;
    r.coefficient  = MAG_WIDTH'(1);
    r.radicand_out = '0;
    r.form_kind    = FORM_ROOT;
    // degree zero wins over everything else
    if (n == 0) begin
      r.status = STATUS_DEG_ZERO;
      return r;
    end
    if (!n[0] && raw[31]) begin
      r.status = STATUS_NEG_EVEN;
      return r;
    end
    coef = 1;
    rem  = 64'(raw);
    // negative with odd degree, 0 and 1: nothing comes out
    if (!raw[31] && rem >= 2) begin
      if (n == 1) begin
        coef = rem;
        rem  = 1;
      end else begin
        d = 2;
        forever begin
          // exact d^n, anything past the remaining radicand ends the search
          p    = 1;
          fits = 1'b1;
          for (i = 0; i < int'(n); i++) begin
            if (p > rem / d) begin
              fits = 1'b0;
              break;
            end
            p = p * d;
          end
          if (!fits || p > rem) break;
          if (rem % p == 0) begin
            rem  = rem / p;
            coef = coef * d;
          end else begin
            d = d + 1;
          end
        end
      end
    end
    r.coefficient  = coef[MAG_WIDTH-1:0];
    r.radicand_out = rem[DATA_WIDTH-1:0];
    if (coef == 1) begin
      r.form_kind = FORM_ROOT;
    end else if (rem == 1) begin
      r.form_kind = FORM_INTEGER;
    end else begin
      r.form_kind = FORM_PRODUCT;
    end
    return r;
  endfunction

  // bounds the radicand so the last candidate d stays small for low degrees
  function automatic longint unsigned magnitude_cap(int n);
    if (n == 2) return 64'h3FFF;
    if (n == 3) return 64'h1F_FFFF;
    return POS_MAX;
  endfunction

  task automatic add_request(input logic [5:0] n, input logic [31:0] r);
    request_t q;
    q.root_degree = n;
    q.radicand_in = r;
    pending_requests.push_back(q);
  endtask

  // driver: one beat per start/busy handshake, random gaps between beats
  always @(posedge clk) begin : driver
    root_check_t entry;
    int          pick;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        entry.req = request;
        entry.res = predict_root(request);
        predicted_roots.push_back(entry);
        accepted_count++;
        if (accepted_count % DRAIN_EVERY == 0) drain_wait = 1'b1;
        // mostly short gaps, some long ones, and runs with none at all
        if (burst_left > 0) begin
          burst_left--;
          gap_left = 0;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 8) begin
            burst_left = $urandom_range(4, 12);
            gap_left   = 0;
          end else if (pick < 45) begin
            gap_left = 0;
          end else if (pick < 85) begin
            gap_left = $urandom_range(1, 3);
          end else if (pick < 97) begin
            gap_left = $urandom_range(4, 20);
          end else begin
            gap_left = $urandom_range(50, 300);
          end
        end
      end
      // a beat still waiting on busy keeps start high untouched
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (drain_wait && predicted_roots.size() != 0) begin
          start <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          drain_wait = 1'b0;
          request <= pending_requests.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done beat is matched against the oldest prediction
  always @(posedge clk) begin : monitor
    root_check_t want;
    if (!rst && done) begin
      if (predicted_roots.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("unexpected result beat: status %0d coef %0d radicand %0d form %0d",
                   result.status, result.coefficient, result.radicand_out, result.form_kind);
      end else begin
        want = predicted_roots.pop_front();
        if (result.status !== want.res.status ||
            result.coefficient !== want.res.coefficient ||
            result.radicand_out !== want.res.radicand_out ||
            result.form_kind !== want.res.form_kind) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("mismatch n=%0d R=%0d: expected status %0d coef %0d radicand %0d form %0d",
                     want.req.root_degree, want.req.radicand_in,
                     want.res.status, want.res.coefficient, want.res.radicand_out,
                     want.res.form_kind);
            $display("  got status %0d coef %0d radicand %0d form %0d",
                     result.status, result.coefficient, result.radicand_out,
                     result.form_kind);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int              i;
    int              j;
    int              n;
    int              pick;
    longint unsigned k;
    longint unsigned kpow;
    longint unsigned mcap;
    longint unsigned m;
    logic [31:0]     r;

    // degree zero and even roots of negatives
    add_request(0, 32'h0000_0000);
    add_request(0, 32'h8000_0000);
    add_request(62, 32'hFFFF_FFFF);
    add_request(2, 32'h8000_0000);
    // odd roots of negatives pass through untouched
    add_request(63, 32'h8000_0000);
    add_request(3, 32'hFFFF_FFE5);
    add_request(1, 32'hFFFF_FFFB);
    // radicands 0 and 1, and degree one
    add_request(2, 32'd0);
    add_request(5, 32'd1);
    add_request(1, 32'd0);
    add_request(1, 32'd1);
    add_request(1, 32'h7FFF_FFFF);
    // bare roots, products and whole integers
    add_request(2, 32'd2);
    add_request(2, 32'd72);
    add_request(2, 32'h4000_0000);
    add_request(30, 32'h4000_0000);
    add_request(31, 32'h7FFF_FFFF);
    add_request(63, 32'h7FFF_FFFF);
    add_request(3, 32'h7FFF_FFFF);
    add_request(3, 32'd1162261467);
    add_request(2, 32'd2147395600);
    add_request(4, 32'h7FFF_FFF0);
    add_request(5, 32'd1701);
    add_request(6, 32'd64);

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // error cases
        if ($urandom_range(0, 1) == 0) begin
          add_request(0, $urandom());
        end else begin
          add_request(6'(2 * $urandom_range(1, 31)), $urandom() | 32'h8000_0000);
        end
      end else if (pick < 20) begin
        add_request(6'(2 * $urandom_range(0, 31) + 1), $urandom() | 32'h8000_0000);
      end else if (pick < 65) begin
        // k^n times a leftover, so the search really divides something out
        pick = $urandom_range(0, 99);
        if (pick < 50) n = $urandom_range(2, 4);
        else if (pick < 85) n = $urandom_range(5, 12);
        else n = $urandom_range(13, 30);
        k = $urandom_range(2, 200);
        do begin
          kpow = 1;
          for (j = 0; j < n; j++)
            if (kpow <= POS_MAX) kpow = kpow * k;
          if (kpow > POS_MAX) k = (k > 3) ? k / 2 : 2;
        end while (kpow > POS_MAX);
        mcap = POS_MAX / kpow;
        if (mcap > magnitude_cap(n)) mcap = magnitude_cap(n);
        m = $urandom_range(1, 32'(mcap));
        add_request(6'(n), 32'(kpow * m));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) n = 1;
        else if (pick < 45) n = $urandom_range(2, 4);
        else if (pick < 80) n = $urandom_range(5, 16);
        else n = $urandom_range(17, 63);
        r = $urandom() & 32'(magnitude_cap(n));
        add_request(6'(n), r);
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // all beats handed over, then everything predicted has come back
    do @(negedge clk); while (pending_requests.size() != 0 || start);
    while (predicted_roots.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #RUN_LIMIT_NS;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
